// ===== src/slt_pkg.sv =====
`timescale 1ns / 1ps

package slt_pkg;

   // token kinds
   localparam logic [4:0] KIND_PLUS      = 5'd0;
   localparam logic [4:0] KIND_MINUS     = 5'd1;
   localparam logic [4:0] KIND_STAR      = 5'd2;
   localparam logic [4:0] KIND_SLASH     = 5'd3;
   localparam logic [4:0] KIND_LT        = 5'd4;
   localparam logic [4:0] KIND_GT        = 5'd5;
   localparam logic [4:0] KIND_ASSIGN    = 5'd6;
   localparam logic [4:0] KIND_BANG      = 5'd7;
   localparam logic [4:0] KIND_EQ        = 5'd8;
   localparam logic [4:0] KIND_NOTEQ     = 5'd9;
   localparam logic [4:0] KIND_COMMA     = 5'd10;
   localparam logic [4:0] KIND_SEMICOLON = 5'd11;
   localparam logic [4:0] KIND_LPAREN    = 5'd12;
   localparam logic [4:0] KIND_RPAREN    = 5'd13;
   localparam logic [4:0] KIND_LBRACE    = 5'd14;
   localparam logic [4:0] KIND_RBRACE    = 5'd15;
   localparam logic [4:0] KIND_FN        = 5'd16;
   localparam logic [4:0] KIND_LET       = 5'd17;
   localparam logic [4:0] KIND_TRUE      = 5'd18;
   localparam logic [4:0] KIND_FALSE     = 5'd19;
   localparam logic [4:0] KIND_IF        = 5'd20;
   localparam logic [4:0] KIND_ELSE      = 5'd21;
   localparam logic [4:0] KIND_RETURN    = 5'd22;
   localparam logic [4:0] KIND_EOF       = 5'd23;
   localparam logic [4:0] KIND_INT       = 5'd24;
   localparam logic [4:0] KIND_IDENT     = 5'd25;
   localparam logic [4:0] KIND_ILLEGAL   = 5'd26;

   localparam logic [15:0] FIELD_MAX = 16'hFFFF;

   // keyword table, byte 0 in the low bits
   localparam int KW_BYTES = 6;
   localparam int KW_COUNT = 7;
   localparam logic [KW_BYTES*8-1:0] KW_TEXT [KW_COUNT] = '{
      {32'h0, "n", "f"},
      {24'h0, "t", "e", "l"},
      {16'h0, "e", "u", "r", "t"},
      {8'h0, "e", "s", "l", "a", "f"},
      {32'h0, "f", "i"},
      {16'h0, "e", "s", "l", "e"},
      {"n", "r", "u", "t", "e", "r"}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd2, 3'd3, 3'd4, 3'd5, 3'd2, 3'd4, 3'd6
   };
   localparam logic [4:0] KW_KIND [KW_COUNT] = '{
      KIND_FN, KIND_LET, KIND_TRUE, KIND_FALSE, KIND_IF, KIND_ELSE, KIND_RETURN
   };

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_ASSIGN,
      MODE_BANG,
      MODE_WORD,
      MODE_NUMBER
   } mode_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        last;
   } token_type;

   // up to two result words per accepted source word
   typedef struct packed {
      logic      push0;
      logic      push1;
      token_type slot0;
      token_type slot1;
   } push_type;

   function automatic logic [4:0] kw_kind(input logic [KW_BYTES*8-1:0] text,
                                          input logic [15:0] count);
      logic [4:0]            kind;
      logic [KW_BYTES*8-1:0] mask;
      kind = KIND_IDENT;
      for (int i = 0; i < KW_COUNT; i++) begin
         mask = '0;
         for (int j = 0; j < KW_BYTES; j++) begin
            if (j < int'(KW_LEN[i])) begin
               mask[8*j +: 8] = 8'hFF;
            end
         end
         if (count == 16'(KW_LEN[i]) && (text & mask) == KW_TEXT[i]) begin
            kind = KW_KIND[i];
         end
      end
      return kind;
   endfunction

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

endpackage

// ===== src/slt_lexer.sv =====
`timescale 1ns / 1ps

module slt_lexer import slt_pkg::*; #(
   parameter int OFFSET_BITS     = 16,
   parameter int KEYWORD_MAX_LEN = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] source_byte,
   input  logic       end_of_source,
   output push_type   push
);

   localparam int IdxBits = $clog2(KEYWORD_MAX_LEN);

   mode_type                     mode_ff, mode_in;
   logic [OFFSET_BITS-1:0]       pos_ff, pos_in;
   logic [OFFSET_BITS-1:0]       begin_ff, begin_in;
   logic [15:0]                  count_ff, count_in;
   logic [KEYWORD_MAX_LEN*8-1:0] word_ff, word_in;

   logic      flush_v, start_v;
   token_type flush_tok, start_tok;
   push_type  res;

   function automatic logic [15:0] sat_offset(input logic [OFFSET_BITS-1:0] v);
      logic [31:0] e;
      e = 32'(v);
      return (|e[31:16]) ? FIELD_MAX : e[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         begin_ff <= '0;
         count_ff <= '0;
         word_ff  <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
         count_ff <= count_in;
         word_ff  <= word_in;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      begin_in = begin_ff;
      count_in = count_ff;
      word_in  = word_ff;
      res      = '0;

      // token held from earlier words
      flush_v         = 1'b1;
      flush_tok       = '0;
      flush_tok.start = sat_offset(begin_ff);
      case (mode_ff)
         MODE_ASSIGN: begin
            flush_tok.kind   = KIND_ASSIGN;
            flush_tok.length = 16'd1;
         end
         MODE_BANG: begin
            flush_tok.kind   = KIND_BANG;
            flush_tok.length = 16'd1;
         end
         MODE_WORD: begin
            flush_tok.kind   = kw_kind(word_ff[KW_BYTES*8-1:0], count_ff);
            flush_tok.length = count_ff;
         end
         MODE_NUMBER: begin
            flush_tok.kind   = KIND_INT;
            flush_tok.length = count_ff;
         end
         default: flush_v = 1'b0;
      endcase

      // token opened by this byte
      start_v          = 1'b1;
      start_tok        = '0;
      start_tok.start  = sat_offset(pos_ff);
      start_tok.length = 16'd1;
      case (source_byte)
         " ", "\t", "\n", 8'h0D: start_v = 1'b0;
         "+": start_tok.kind = KIND_PLUS;
         "-": start_tok.kind = KIND_MINUS;
         "*": start_tok.kind = KIND_STAR;
         "/": start_tok.kind = KIND_SLASH;
         "<": start_tok.kind = KIND_LT;
         ">": start_tok.kind = KIND_GT;
         ",": start_tok.kind = KIND_COMMA;
         ";": start_tok.kind = KIND_SEMICOLON;
         "(": start_tok.kind = KIND_LPAREN;
         ")": start_tok.kind = KIND_RPAREN;
         "{": start_tok.kind = KIND_LBRACE;
         "}": start_tok.kind = KIND_RBRACE;
         8'h00: begin
            start_tok.kind   = KIND_EOF;
            start_tok.length = 16'd0;
         end
         "=", "!": start_v = 1'b0;
         default: begin
            if (is_letter(source_byte) || is_digit(source_byte)) begin
               start_v = 1'b0;
            end else begin
               start_tok.kind = KIND_ILLEGAL;
            end
         end
      endcase

      if (end_of_source) begin
         start_v          = 1'b1;
         start_tok        = '0;
         start_tok.kind   = KIND_EOF;
         start_tok.start  = sat_offset(pos_ff);
         mode_in          = MODE_IDLE;
         pos_in           = '0;
         res.push0        = flush_v | start_v;
         res.push1        = flush_v;
         res.slot0        = flush_v ? flush_tok : start_tok;
         res.slot1        = start_tok;
      end else begin
         if (~&pos_ff) begin
            pos_in = pos_ff + OFFSET_BITS'(1);
         end
         if ((mode_ff == MODE_ASSIGN || mode_ff == MODE_BANG) && source_byte == "=") begin
            res.push0        = 1'b1;
            res.slot0.kind   = (mode_ff == MODE_ASSIGN) ? KIND_EQ : KIND_NOTEQ;
            res.slot0.start  = sat_offset(begin_ff);
            res.slot0.length = 16'd2;
            mode_in          = MODE_IDLE;
         end else if ((mode_ff == MODE_WORD &&
                       (is_letter(source_byte) || is_digit(source_byte))) ||
                      (mode_ff == MODE_NUMBER && is_digit(source_byte))) begin
            if (count_ff < 16'(KEYWORD_MAX_LEN)) begin
               word_in[8*count_ff[IdxBits-1:0] +: 8] = source_byte;
            end
            if (count_ff != FIELD_MAX) begin
               count_in = count_ff + 16'd1;
            end
         end else begin
            mode_in = MODE_IDLE;
            if (source_byte == "=") begin
               mode_in  = MODE_ASSIGN;
               begin_in = pos_ff;
            end else if (source_byte == "!") begin
               mode_in  = MODE_BANG;
               begin_in = pos_ff;
            end else if (is_letter(source_byte) || is_digit(source_byte)) begin
               mode_in      = is_letter(source_byte) ? MODE_WORD : MODE_NUMBER;
               begin_in     = pos_ff;
               count_in     = 16'd1;
               word_in      = '0;
               word_in[7:0] = source_byte;
            end
            res.push0 = flush_v | start_v;
            res.push1 = flush_v & start_v;
            res.slot0 = flush_v ? flush_tok : start_tok;
            res.slot1 = start_tok;
         end
      end

      if (res.push1) begin
         res.slot1.last = 1'b1;
      end else if (res.push0) begin
         res.slot0.last = 1'b1;
      end

      push       = res;
      push.push0 = res.push0 & accept;
      push.push1 = res.push1 & accept;
   end

endmodule

// ===== src/slt_fifo.sv =====
`timescale 1ns / 1ps

module slt_fifo import slt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   output logic      full,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output token_type rsp_token
);

   token_type                mem [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ff, wr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ff, rd_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic [1:0]               npush;
   logic                     pop;

   assign npush     = 2'(push.push0) + 2'(push.push1);
   assign pop       = rsp_valid & ~rsp_stall;
   assign rsp_valid = count_ff != '0;
   assign rsp_token = mem[rd_ff];
   // two free entries are needed before a source word can be taken
   assign full      = count_ff > FIFO_CNT_BITS'(FIFO_DEPTH - 2);

   always_comb begin
      wr_in    = wr_ff + FIFO_PTR_BITS'(npush);
      rd_in    = rd_ff + FIFO_PTR_BITS'(pop);
      count_in = count_ff + FIFO_CNT_BITS'(npush) - FIFO_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem[wr_ff] <= push.slot0;
      end
      if (push.push1) begin
         mem[wr_ff + FIFO_PTR_BITS'(1)] <= push.slot1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== src/small_language_tokenizer_core.sv =====
`timescale 1ns / 1ps

// channel | direction | handshake            | payload
// req     | in        | req_valid, req_stall | req_source_byte, req_end_of_source
// rsp     | out       | rsp_valid, rsp_stall | rsp_token_kind/start/length, rsp_last_of_run
//
// One source word per cycle while req_stall is low. Each word is lexed in the cycle it
// is taken and its zero, one or two tokens land in a four-word result queue; a token
// shows on rsp once earlier tokens are popped. req_stall rises only while the queue
// holds over two words; one word per cycle holds unless rsp stalls or tokens back up.
// Synchronous reset returns the lexer to idle at offset zero and empties the queue.

module small_language_tokenizer_core import slt_pkg::*; #(
   parameter int OFFSET_BITS     = 16,
   parameter int KEYWORD_MAX_LEN = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_source_byte,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_run
);

   push_type  push;
   token_type token;
   logic      full;
   logic      accept;

   assign req_stall = full;
   assign accept    = req_valid & ~full;

   slt_lexer #(
      .OFFSET_BITS     (OFFSET_BITS),
      .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
   ) u_lexer (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .source_byte   (req_source_byte),
      .end_of_source (req_end_of_source),
      .push          (push)
   );

   slt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_token (token)
   );

   assign rsp_token_kind   = token.kind;
   assign rsp_token_start  = token.start;
   assign rsp_token_length = token.length;
   assign rsp_last_of_run  = token.last;

endmodule
